// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the object table lookup engine.
// Holds macro definitions only; it depends on no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define OTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/ote_pkg.sv
// Package of the object table lookup engine: codes, entry layout, constants.
// Used by every module in rtl/core; depends on nothing.
package ote_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned ENTRY_BYTES     = 6;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PARTIAL_W       = (ENTRY_BYTES - 1) * BYTE_W;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned COUNT_OUT_W     = 7;
  localparam int unsigned EXT_W           = 17;
  localparam logic [2:0]  LAST_PHASE      = 3'(ENTRY_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // One stored entry, 50 bits; the first member is the most significant.
  typedef struct packed {
    logic [7:0]  report_ids;
    logic [8:0]  instance_count;
    logic [8:0]  obj_size;
    logic [15:0] start_address;
    logic [7:0]  obj_type;
  } entry_t;

  // Control of the extent unit.
  typedef struct packed {
    logic clear;
    logic start;
  } ext_ctl_t;

endpackage

// File: rtl/core/ote_entry_mem.sv
// Entry store of the object table lookup engine: one write and one read port.
// Depends on ote_pkg for the entry layout.
module ote_entry_mem #(
  parameter int unsigned DEPTH = ote_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ote_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ote_pkg::entry_t rdata_o
);
  import ote_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ote_extent_unit.sv
// Extent unit: multiplies size by instances, then adds the start and keeps the maximum end.
// Depends on ote_pkg for the entry layout and the control struct.
module ote_extent_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ote_pkg::ext_ctl_t         ctl_i,
  input  ote_pkg::entry_t           entry_i,
  output logic [ote_pkg::EXT_W-1:0] max_end_o
);
  import ote_pkg::*;

  logic [2*9-1:0]   prod_w;
  logic [EXT_W-1:0] prod_q;
  logic [15:0]      addr_q;
  logic [EXT_W-1:0] end_w;
  logic             pend_q;
  logic [EXT_W-1:0] max_q;

  assign prod_w = 18'(entry_i.obj_size) * 18'(entry_i.instance_count);
  // The product never exceeds 65536, so the sum stays within 17 bits.
  assign end_w  = EXT_W'(addr_q) + prod_q - EXT_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      addr_q <= entry_i.start_address;
      prod_q <= prod_w[EXT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      max_q  <= '0;
    end else if (ctl_i.clear) begin
      pend_q <= 1'b0;
      max_q  <= '0;
    end else begin
      pend_q <= ctl_i.start;
      if (pend_q && (end_w > max_q)) begin
        max_q <= end_w;
      end
    end
  end

  assign max_end_o = max_q;

endmodule

// File: rtl/core/object_table_lookup_engine_top.sv
// Top level of the object table lookup engine: command sequencer, byte assembly, scan.
// Depends on ote_pkg, assert_macros.svh, ote_entry_mem and ote_extent_unit.
//
// Usage. Each input item carries a command: clear the table, load one table byte, find the
// first entry of a given type, or read the entry at a given position. Table bytes arrive six
// to an entry (type, start address low and high, size minus one, instances minus one,
// report-id count); last_byte_i marks the final byte of a table. Every item gives exactly
// one result item with a status, the entry found (zeros otherwise), the entry count and the
// memory extent.
// Both channels use valid and stall. The block takes one item at a time and raises
// in_stall_o from the cycle after acceptance until the result has entered the output
// register; a result waiting there does not stop the next item from being accepted.
// After acceptance a clear goes straight to the finish state; a load byte passes the
// load and load-end states, and one that stores an entry also the extent state (the
// extent multiplier and its add-compare stage run in turn); a read by index checks the
// index and reads the entry if it is valid; a find ends at the first hit or after the
// last stored entry, paced by the single read port of the entry store, which the shared
// type comparator walks one entry per cycle. The next item can be accepted once the
// result has entered the output register. While out_stall_i is high the result holds in
// the output register and a finished next result waits in the sequencer. Reset clears the
// count, the byte phase and the extent; the store needs no clearing, since only entries
// below the count are read.
`include "assert_macros.svh"

module object_table_lookup_engine_top #(
  parameter int unsigned MAX_ENTRIES = ote_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  load_byte_i,
  input  logic        last_byte_i,
  input  logic [7:0]  lookup_key_i,
  input  logic [5:0]  lookup_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        found_o,
  output logic [7:0]  obj_type_o,
  output logic [15:0] start_address_o,
  output logic [8:0]  obj_size_o,
  output logic [8:0]  instance_count_o,
  output logic [7:0]  report_ids_o,
  output logic [6:0]  entry_count_o,
  output logic [16:0] memory_extent_o
);
  import ote_pkg::*;

  // Address width of the store, and count width that can hold MAX_ENTRIES itself.
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EXT,
    S_LOAD_END,
    S_SCAN,
    S_IDX,
    S_IDX_RD,
    S_FINISH
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [BYTE_W-1:0]    byte_q;
  logic                 last_q;
  logic [BYTE_W-1:0]    key_q;
  logic [IDX_W-1:0]     idx_q;
  logic [2:0]           phase_q;
  logic [PARTIAL_W-1:0] partial_q;
  logic [CW-1:0]        stored_q;
  logic                 ovf_q;
  logic [CW-1:0]        scan_q;
  logic                 rd_pend_q;
  status_e              res_status_q;
  logic                 res_found_q;
  entry_t               res_entry_q;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic                 out_found_q;
  entry_t               out_entry_q;
  logic [COUNT_OUT_W-1:0] out_count_q;
  logic [EXT_W-1:0]     out_extent_q;

  logic                 room;
  logic                 complete;
  logic                 idx_ok;
  logic                 hit;
  logic                 out_load;
  entry_t               new_entry;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  entry_t               mem_rdata;
  ext_ctl_t             ext_ctl;
  logic [EXT_W-1:0]     max_end;

  assign in_stall_o = (state_q != S_IDLE);
  assign room       = (stored_q < CW'(MAX_ENTRIES));
  assign complete   = (phase_q == LAST_PHASE);
  assign idx_ok     = (XW'(idx_q) < XW'(stored_q));
  // The shared comparator: the type of the entry read in the previous cycle against the key.
  assign hit        = rd_pend_q && (mem_rdata.obj_type == key_q);
  // The finished result moves into the output register once that register is free or taken.
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    new_entry.obj_type       = partial_q[7:0];
    new_entry.start_address  = partial_q[23:8];
    new_entry.obj_size       = 9'(partial_q[31:24]) + 9'd1;
    new_entry.instance_count = 9'(partial_q[39:32]) + 9'd1;
    new_entry.report_ids     = byte_q;
  end

  always_comb begin
    mem_we        = (state_q == S_LOAD) && complete && room;
    ext_ctl.start = mem_we;
    ext_ctl.clear = (state_q == S_IDLE) && in_valid_i && (cmd_e'(cmd_i) == CMD_CLEAR);
    mem_re        = 1'b0;
    mem_raddr     = scan_q[AW-1:0];
    unique case (state_q)
      S_SCAN: begin
        mem_re = !hit && (scan_q < stored_q);
      end
      S_IDX: begin
        mem_re    = idx_ok;
        mem_raddr = AW'(idx_q);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  ote_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (stored_q[AW-1:0]),
    .wdata_i (new_entry),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ote_extent_unit u_extent_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ext_ctl),
    .entry_i   (new_entry),
    .max_end_o (max_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_CLEAR;
      byte_q       <= '0;
      last_q       <= 1'b0;
      key_q        <= '0;
      idx_q        <= '0;
      phase_q      <= '0;
      partial_q    <= '0;
      stored_q     <= '0;
      ovf_q        <= 1'b0;
      scan_q       <= '0;
      rd_pend_q    <= 1'b0;
      res_status_q <= ST_OK;
      res_found_q  <= 1'b0;
      res_entry_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_found_q  <= 1'b0;
      out_entry_q  <= '0;
      out_count_q  <= '0;
      out_extent_q <= '0;
    end else begin
      // A new result enters when the register is free or its result is taken; otherwise a taken result leaves it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q        <= cmd_e'(cmd_i);
            byte_q       <= load_byte_i;
            last_q       <= last_byte_i;
            key_q        <= lookup_key_i;
            idx_q        <= lookup_index_i;
            scan_q       <= '0;
            rd_pend_q    <= 1'b0;
            res_status_q <= ST_OK;
            res_found_q  <= 1'b0;
            res_entry_q  <= '0;
            unique case (cmd_e'(cmd_i))
              CMD_CLEAR: begin
                stored_q  <= '0;
                phase_q   <= '0;
                partial_q <= '0;
                ovf_q     <= 1'b0;
                state_q   <= S_FINISH;
              end
              CMD_LOAD: begin
                state_q <= S_LOAD;
              end
              CMD_FIND: begin
                state_q <= S_SCAN;
              end
              CMD_READ: begin
                state_q <= S_IDX;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (!complete) begin
            partial_q[{phase_q, 3'b000} +: BYTE_W] <= byte_q;
            phase_q <= phase_q + 3'd1;
            state_q <= S_LOAD_END;
          end else begin
            phase_q   <= '0;
            partial_q <= '0;
            if (room) begin
              stored_q <= stored_q + CW'(1);
              state_q  <= S_EXT;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= S_LOAD_END;
            end
          end
        end
        S_EXT: begin
          state_q <= S_LOAD_END;
        end
        S_LOAD_END: begin
          if (!last_q) begin
            res_status_q <= ovf_q ? ST_OVERFLOW : ST_OK;
          end else begin
            priority if (ovf_q) begin
              res_status_q <= ST_OVERFLOW;
            end else if ((phase_q != 3'd0) || (stored_q == '0)) begin
              res_status_q <= ST_BAD_LEN;
            end else begin
              res_status_q <= ST_OK;
            end
            phase_q   <= '0;
            partial_q <= '0;
            ovf_q     <= 1'b0;
          end
          state_q <= S_FINISH;
        end
        S_SCAN: begin
          priority if (hit) begin
            res_found_q  <= 1'b1;
            res_entry_q  <= mem_rdata;
            res_status_q <= ST_OK;
            state_q      <= S_FINISH;
          end else if (scan_q < stored_q) begin
            scan_q    <= scan_q + CW'(1);
            rd_pend_q <= 1'b1;
          end else begin
            res_status_q <= ST_MISS;
            state_q      <= S_FINISH;
          end
        end
        S_IDX: begin
          if (idx_ok) begin
            state_q <= S_IDX_RD;
          end else begin
            res_status_q <= ST_MISS;
            state_q      <= S_FINISH;
          end
        end
        S_IDX_RD: begin
          res_found_q <= 1'b1;
          res_entry_q <= mem_rdata;
          state_q     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            out_status_q <= res_status_q;
            out_found_q  <= res_found_q;
            out_entry_q  <= res_entry_q;
            out_count_q  <= COUNT_OUT_W'(stored_q);
            out_extent_q <= max_end + EXT_W'(1);
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_o          = out_found_q;
  assign obj_type_o       = out_entry_q.obj_type;
  assign start_address_o  = out_entry_q.start_address;
  assign obj_size_o       = out_entry_q.obj_size;
  assign instance_count_o = out_entry_q.instance_count;
  assign report_ids_o     = out_entry_q.report_ids;
  assign entry_count_o    = out_count_q;
  assign memory_extent_o  = out_extent_q;

  `OTE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, stored_q <= CW'(MAX_ENTRIES))
  `OTE_ASSERT_IMPL(a_phase_bound, clk_i, rst_ni, 1'b1, phase_q <= LAST_PHASE)
  `OTE_ASSERT_IMPL(a_write_has_room, clk_i, rst_ni, mem_we, room && (cmd_q == CMD_LOAD))
  `OTE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule
